[src/mia_pkg.sv]
// ----------------------------------------------------------------------------
// mia_pkg
// shared types, selector codes and the operation decoder for the integer alu
// ----------------------------------------------------------------------------
package mia_pkg;

  localparam int DATA_BITS_DEF = 32;
  localparam int LUI_SHIFT     = 16;

  // primary opcodes with special meaning
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2B;

  // selector codes (function codes and immediate opcodes share one space)
  localparam logic [5:0] SEL_SLL   = 6'h00;
  localparam logic [5:0] SEL_SRL   = 6'h02;
  localparam logic [5:0] SEL_SRA   = 6'h03;
  localparam logic [5:0] SEL_SLLV  = 6'h04;
  localparam logic [5:0] SEL_SRLV  = 6'h06;
  localparam logic [5:0] SEL_SRAV  = 6'h07;
  localparam logic [5:0] SEL_ADDI  = 6'h08;
  localparam logic [5:0] SEL_ADDIU = 6'h09;
  localparam logic [5:0] SEL_SLTI  = 6'h0A;
  localparam logic [5:0] SEL_SLTIU = 6'h0B;
  localparam logic [5:0] SEL_ANDI  = 6'h0C;
  localparam logic [5:0] SEL_ORI   = 6'h0D;
  localparam logic [5:0] SEL_XORI  = 6'h0E;
  localparam logic [5:0] SEL_LUI   = 6'h0F;
  localparam logic [5:0] SEL_DIV   = 6'h1A;
  localparam logic [5:0] SEL_DIVU  = 6'h1B;
  localparam logic [5:0] SEL_ADD   = 6'h20;
  localparam logic [5:0] SEL_ADDU  = 6'h21;
  localparam logic [5:0] SEL_SUB   = 6'h22;
  localparam logic [5:0] SEL_SUBU  = 6'h23;
  localparam logic [5:0] SEL_AND   = 6'h24;
  localparam logic [5:0] SEL_OR    = 6'h25;
  localparam logic [5:0] SEL_XOR   = 6'h26;
  localparam logic [5:0] SEL_NOR   = 6'h27;
  localparam logic [5:0] SEL_SLT   = 6'h2A;
  localparam logic [5:0] SEL_SLTU  = 6'h2B;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_NOR,
    OP_SLT,
    OP_SLTU,
    OP_SLL,
    OP_SRL,
    OP_SRA,
    OP_LUI,
    OP_DIV,
    OP_DIVU,
    OP_NONE
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // non-divide op, write result straight away
    logic div_start;   // latch divide operands
    logic div_step;    // one quotient bit
    logic div_finish;  // write divide result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;
    logic div_last;
  } dp_sts_t;

  function automatic op_e decode_op(logic [5:0] opcode, logic [5:0] func);
    logic [5:0] sel;
    op_e        op;
    if (opcode == OPC_RTYPE) begin
      sel = func;
    end else if (opcode == OPC_LW || opcode == OPC_SW) begin
      sel = SEL_ADD;
    end else begin
      sel = opcode;
    end
    unique case (sel)
      SEL_ADD, SEL_ADDI, SEL_ADDU, SEL_ADDIU: op = OP_ADD;
      SEL_SUB, SEL_SUBU:                      op = OP_SUB;
      SEL_AND, SEL_ANDI:                      op = OP_AND;
      SEL_OR, SEL_ORI:                        op = OP_OR;
      SEL_XOR, SEL_XORI:                      op = OP_XOR;
      SEL_NOR:                                op = OP_NOR;
      SEL_SLT, SEL_SLTI:                      op = OP_SLT;
      SEL_SLTU, SEL_SLTIU:                    op = OP_SLTU;
      SEL_SLL, SEL_SLLV:                      op = OP_SLL;
      SEL_SRL, SEL_SRLV:                      op = OP_SRL;
      SEL_SRA, SEL_SRAV:                      op = OP_SRA;
      SEL_LUI:                                op = OP_LUI;
      SEL_DIV:                                op = OP_DIV;
      SEL_DIVU:                               op = OP_DIVU;
      default:                                op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

[src/mia_dp.sv]
// ----------------------------------------------------------------------------
// mia_dp
// alu datapath: decoder, combinational alu ops, radix-2 divider, result registers
// ----------------------------------------------------------------------------
module mia_dp #(
  parameter int DATA_BITS = mia_pkg::DATA_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [5:0]            opcode_i,
  input  logic [5:0]            func_i,
  input  logic [DATA_BITS-1:0]  operand_a_i,
  input  logic [DATA_BITS-1:0]  operand_b_i,
  input  logic                  clear_i,
  input  mia_pkg::ctrl_cmd_t    cmd_i,
  output mia_pkg::dp_sts_t      sts_o,
  output logic [DATA_BITS-1:0]  result_o,
  output logic                  zero_flag_o,
  output logic                  recognized_o
);
  import mia_pkg::*;

  localparam int CW = $clog2(DATA_BITS);

  op_e                  op;
  logic [CW-1:0]        sh;
  logic [DATA_BITS-1:0] alu_r;
  logic                 alu_hit;
  logic                 eq;

  logic [DATA_BITS-1:0] held_q, held_d;
  logic [DATA_BITS-1:0] res_q, res_d;
  logic                 zero_q, zero_d;
  logic                 recog_q, recog_d;

  logic [DATA_BITS-1:0] rem_q, rem_d;
  logic [DATA_BITS-1:0] quo_q, quo_d;
  logic [DATA_BITS-1:0] mb_q, mb_d;
  logic                 neg_q, neg_d;
  logic                 dzero_q, dzero_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  logic                 a_neg, b_neg;
  logic [DATA_BITS:0]   shifted, diff;
  logic                 ge;
  logic [DATA_BITS-1:0] div_r;

  assign op = decode_op(opcode_i, func_i);
  assign sh = operand_b_i[CW-1:0];
  assign eq = (operand_a_i == operand_b_i);

  always_comb begin
    alu_hit = !clear_i;
    alu_r   = '0;
    unique case (op)
      OP_ADD:  alu_r = operand_a_i + operand_b_i;
      OP_SUB:  alu_r = operand_a_i - operand_b_i;
      OP_AND:  alu_r = operand_a_i & operand_b_i;
      OP_OR:   alu_r = operand_a_i | operand_b_i;
      OP_XOR:  alu_r = operand_a_i ^ operand_b_i;
      OP_NOR:  alu_r = ~(operand_a_i | operand_b_i);
      OP_SLT:  alu_r = DATA_BITS'($signed(operand_a_i) < $signed(operand_b_i));
      OP_SLTU: alu_r = DATA_BITS'(operand_a_i < operand_b_i);
      OP_SLL:  alu_r = operand_a_i << sh;
      OP_SRL:  alu_r = operand_a_i >> sh;
      OP_SRA:  alu_r = DATA_BITS'($signed(operand_a_i) >>> sh);
      OP_LUI:  alu_r = operand_b_i << LUI_SHIFT;
      default: alu_hit = 1'b0;  // divides go through the divider, unknown holds
    endcase
  end

  assign sts_o.is_div   = !clear_i && (op == OP_DIV || op == OP_DIVU);
  assign sts_o.div_last = (cnt_q == CW'(DATA_BITS - 1));

  // operand magnitudes for the signed form
  assign a_neg = (op == OP_DIV) && operand_a_i[DATA_BITS-1];
  assign b_neg = (op == OP_DIV) && operand_b_i[DATA_BITS-1];

  // restoring step: bring down one dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[DATA_BITS-1]};
  assign diff    = shifted - {1'b0, mb_q};
  assign ge      = !diff[DATA_BITS];

  // zero divisor yields all ones from the loop; sign fix is suppressed then
  assign div_r = neg_q ? ('0 - quo_q) : quo_q;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    mb_d    = mb_q;
    neg_d   = neg_q;
    dzero_d = dzero_q;
    cnt_d   = cnt_q;
    if (cmd_i.div_start) begin
      rem_d   = '0;
      quo_d   = a_neg ? ('0 - operand_a_i) : operand_a_i;
      mb_d    = b_neg ? ('0 - operand_b_i) : operand_b_i;
      neg_d   = (a_neg ^ b_neg) && (operand_b_i != '0);
      dzero_d = eq;
      cnt_d   = '0;
    end else if (cmd_i.div_step) begin
      rem_d = ge ? diff[DATA_BITS-1:0] : shifted[DATA_BITS-1:0];
      quo_d = {quo_q[DATA_BITS-2:0], ge};
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_comb begin
    held_d  = held_q;
    res_d   = res_q;
    zero_d  = zero_q;
    recog_d = recog_q;
    if (cmd_i.load) begin
      held_d  = alu_hit ? alu_r : held_q;
      res_d   = held_d;
      zero_d  = !clear_i && eq;
      recog_d = alu_hit;
    end else if (cmd_i.div_finish) begin
      held_d  = div_r;
      res_d   = div_r;
      zero_d  = dzero_q;
      recog_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    mb_q    <= mb_d;
    neg_q   <= neg_d;
    dzero_q <= dzero_d;
    res_q   <= res_d;
    zero_q  <= zero_d;
    recog_q <= recog_d;
  end

  assign result_o     = res_q;
  assign zero_flag_o  = zero_q;
  assign recognized_o = recog_q;

endmodule

[src/mia_ctrl.sv]
// ----------------------------------------------------------------------------
// mia_ctrl
// sequencer: handshakes, divide iteration control, output valid
// ----------------------------------------------------------------------------
module mia_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mia_pkg::dp_sts_t   sts_i,
  output mia_pkg::ctrl_cmd_t cmd_o
);
  import mia_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  // output register can take a beat this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.is_div) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            cmd_o.load  = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.div_finish = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load || cmd_o.div_finish) |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while holding a stalled beat");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.div_start))
    else $error("single-cycle load and divide start in the same cycle");

  a_div_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_DIV && cmd_o.div_step))
    else $error("divide start not followed by iteration");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_DONE))
    else $error("divider did not finish after last step");
`endif

endmodule

[src/mips_integer_alu_top.sv]
// ----------------------------------------------------------------------------
// mips_integer_alu_top
// mips32 integer alu with held result and iterative divider
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Logic, arithmetic, compare, shift and lui
// operations bypass the divider: the result lands in the output register at
// the accepting edge and the next beat can be accepted in the following cycle,
// so the sustained rate is one beat per cycle while the output is not stalled.
// div and divu run through a radix-2 restoring divider that produces one
// quotient bit per cycle, so a divide beat occupies the block for accept, one
// iteration per bit and write back, with in_stall_o high meanwhile. A beat
// with clear_i high, or with an unknown operation, keeps the held result and
// reports recognized_o low. The output register decouples the two sides: a
// new beat is taken in the same cycle the waiting result is drained.
// ----------------------------------------------------------------------------
module mips_integer_alu_top #(
  parameter int DATA_BITS = mia_pkg::DATA_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [5:0]           opcode_i,
  input  logic [5:0]           func_i,
  input  logic [DATA_BITS-1:0] operand_a_i,
  input  logic [DATA_BITS-1:0] operand_b_i,
  input  logic                 clear_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_BITS-1:0] result_o,
  output logic                 zero_flag_o,
  output logic                 recognized_o
);
  import mia_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: owns handshakes and the divide iteration
  mia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: decode, alu, divider, held and output registers
  mia_dp #(
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .func_i       (func_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .clear_i      (clear_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .result_o     (result_o),
    .zero_flag_o  (zero_flag_o),
    .recognized_o (recognized_o)
  );

endmodule

[verif/mips_integer_alu_top_test.sv]
// ----------------------------------------------------------------------------
// mips_integer_alu_top_test
// self-checking bench for the mips32 integer alu with held result
// ----------------------------------------------------------------------------
// A clocked driver presents instruction beats from a queue that the stimulus
// block fills: first a directed set (wrap-around, shift masking, lui, divide
// by zero and overflow, clear, unknown selectors, opcode aliasing, load and
// store), then randomly weighted instructions and operands. At every accepted
// beat an in-bench model of the alu updates its own held result and queues
// the outcome it predicts. A clocked monitor compares each delivered result
// field by field with the oldest prediction. Both sides insert random idle
// cycles whose density changes from stretch to stretch.
// ----------------------------------------------------------------------------
module mips_integer_alu_top_test;
  import mia_pkg::*;

  localparam int W           = DATA_BITS_DEF;
  localparam int RANDOM_BEATS = 1530;
  localparam int SETTLE_CYCLES = 3 * (W + 2);
  localparam int CYCLE_LIMIT  = 600000;

  // one instruction beat plus its pacing
  typedef struct {
    logic [5:0]   opcode;
    logic [5:0]   func;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         clr;
    int           gap;    // idle cycles before this beat is offered
    bit           drain;  // hold off until every result has come back
  } alu_instr_t;

  // what the alu must deliver for one beat
  typedef struct {
    logic [W-1:0] result;
    logic         zero;
    logic         recognized;
  } alu_outcome_t;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  logic [5:0]   opcode_i    = '0;
  logic [5:0]   func_i      = '0;
  logic [W-1:0] operand_a_i = '0;
  logic [W-1:0] operand_b_i = '0;
  logic         clear_i     = 1'b0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] result_o;
  logic         zero_flag_o;
  logic         recognized_o;

  alu_instr_t   instr_queue[$];
  alu_outcome_t alu_results_due[$];
  logic [W-1:0] held_value = '0;   // model copy of the alu's result register
  int           mismatches = 0;
  int           cycle_count = 0;
  logic [5:0]   rtype_funcs[$];
  logic [5:0]   imm_opcodes[$];

  mips_integer_alu_top #(.DATA_BITS(W)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .func_i       (func_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .clear_i      (clear_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result_o),
    .zero_flag_o  (zero_flag_o),
    .recognized_o (recognized_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mips_integer_alu_top_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // alu model: decodes the selector the way the hardware does and updates the
  // held result only when an operation is selected and clear is low
  // ---------------------------------------------------------------------------
  function automatic alu_outcome_t predict_alu(alu_instr_t ins);
    alu_outcome_t o;
    logic [5:0]   sel;
    logic [4:0]   sh;
    logic [W-1:0] r;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] quo;
    bit           hit;
    o.zero       = 1'b0;
    o.recognized = 1'b0;
    if (!ins.clr) begin
      o.zero = (ins.a == ins.b);
      sh     = ins.b[4:0];     // shifts look at the low five bits only
      if (ins.opcode == OPC_RTYPE) begin
        sel = ins.func;
      end else if (ins.opcode == OPC_LW || ins.opcode == OPC_SW) begin
        sel = SEL_ADD;           // address calculation
      end else begin
        sel = ins.opcode;        // immediate opcodes share the function space
      end
      hit = 1'b1;
      r   = '0;
      case (sel)
        SEL_ADD, SEL_ADDI, SEL_ADDU, SEL_ADDIU: r = ins.a + ins.b;
        SEL_SUB, SEL_SUBU:                      r = ins.a - ins.b;
        SEL_AND, SEL_ANDI:                      r = ins.a & ins.b;
        SEL_OR, SEL_ORI:                        r = ins.a | ins.b;
        SEL_XOR, SEL_XORI:                      r = ins.a ^ ins.b;
        SEL_NOR:                                r = ~(ins.a | ins.b);
        SEL_SLT, SEL_SLTI:  r = ($signed(ins.a) < $signed(ins.b)) ? 1 : 0;
        SEL_SLTU, SEL_SLTIU: r = (ins.a < ins.b) ? 1 : 0;
        SEL_SLL, SEL_SLLV:  r = ins.a << sh;
        SEL_SRL, SEL_SRLV:  r = ins.a >> sh;
        SEL_SRA, SEL_SRAV:  r = $signed(ins.a) >>> sh;
        SEL_LUI:            r = ins.b << LUI_SHIFT;
        SEL_DIV: begin
          if (ins.b == '0) begin
            r = '1;
          end else begin
            // magnitudes, so the most negative value over -1 wraps onto itself
            mag_a = ins.a[W-1] ? ('0 - ins.a) : ins.a;
            mag_b = ins.b[W-1] ? ('0 - ins.b) : ins.b;
            quo   = mag_a / mag_b;
            r     = (ins.a[W-1] ^ ins.b[W-1]) ? ('0 - quo) : quo;
          end
        end
        SEL_DIVU: r = (ins.b == '0) ? '1 : ins.a / ins.b;
        default:  hit = 1'b0;
      endcase
      if (hit) begin
        held_value = r;
      end
      o.recognized = hit;
    end
    o.result = held_value;
    return o;
  endfunction

  // idle cycles for one beat: 0 = no idling, 1 = light, 2 = heavy
  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      default: return $urandom_range(0, 10);
    endcase
  endfunction

  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(W-1){1'b0}}};
      3:       return {1'b0, {(W-1){1'b1}}};
      4:       return $urandom_range(0, 40);
      5:       return '0 - $urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_instr(logic [5:0] opc, logic [5:0] fn, logic [W-1:0] a,
                           logic [W-1:0] b, logic clr, int gap, bit drain);
    alu_instr_t ins;
    ins.opcode = opc;
    ins.func   = fn;
    ins.a      = a;
    ins.b      = b;
    ins.clr    = clr;
    ins.gap    = gap;
    ins.drain  = drain;
    instr_queue.push_back(ins);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the head of the instruction queue once its idle count has
  // run out; a stalled beat stays on the pins unchanged
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_side
    alu_instr_t cur;
    int         idle_left;
    bit         gap_armed;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      opcode_i    <= '0;
      func_i      <= '0;
      operand_a_i <= '0;
      operand_b_i <= '0;
      clear_i     <= 1'b0;
      gap_armed   = 1'b0;
      idle_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        alu_results_due.push_back(predict_alu(cur));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (instr_queue.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (instr_queue[0].drain && alu_results_due.size() != 0) begin
          // pause until the block has handed back everything in flight
          in_valid_i <= 1'b0;
        end else begin
          if (!gap_armed) begin
            idle_left = instr_queue[0].gap;
            gap_armed = 1'b1;
          end
          if (idle_left > 0) begin
            idle_left--;
            in_valid_i <= 1'b0;
          end else begin
            cur = instr_queue.pop_front();
            gap_armed = 1'b0;
            in_valid_i  <= 1'b1;
            opcode_i    <= cur.opcode;
            func_i      <= cur.func;
            operand_a_i <= cur.a;
            operand_b_i <= cur.b;
            clear_i     <= cur.clr;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes result beats, checks them against the oldest prediction
  // and stalls for a random number of cycles after each one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_side
    alu_outcome_t due;
    int           stall_left;
    int           rx_mode;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      rx_mode     = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (alu_results_due.size() == 0) begin
          $display("%0t: unexpected result beat, result %h zero %b recognized %b",
                   $time, result_o, zero_flag_o, recognized_o);
          mismatches++;
        end else begin
          due = alu_results_due.pop_front();
          if (result_o !== due.result) begin
            $display("%0t: result expected %h actual %h", $time, due.result, result_o);
            mismatches++;
          end
          if (zero_flag_o !== due.zero) begin
            $display("%0t: zero_flag expected %b actual %b", $time, due.zero, zero_flag_o);
            mismatches++;
          end
          if (recognized_o !== due.recognized) begin
            $display("%0t: recognized expected %b actual %b",
                     $time, due.recognized, recognized_o);
            mismatches++;
          end
        end
        // change stall density now and then
        if ($urandom_range(0, 47) == 0) begin
          rx_mode = $urandom_range(0, 2);
        end
        stall_left = draw_wait(rx_mode);
        out_stall_i <= (stall_left != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [5:0]   opc;
    logic [5:0]   fn;
    logic         clr;
    int           tx_mode;
    int           stretch;
    int           kind;

    rtype_funcs = '{SEL_SLL, SEL_SRL, SEL_SRA, SEL_SLLV, SEL_SRLV, SEL_SRAV,
                    SEL_DIV, SEL_DIVU, SEL_ADD, SEL_ADDU, SEL_SUB, SEL_SUBU,
                    SEL_AND, SEL_OR, SEL_XOR, SEL_NOR, SEL_SLT, SEL_SLTU};
    imm_opcodes = '{SEL_ADDI, SEL_ADDIU, SEL_SLTI, SEL_SLTIU, SEL_ANDI,
                    SEL_ORI, SEL_XORI, SEL_LUI};

    // directed: unknown selector right after reset keeps the zero result
    add_instr(OPC_RTYPE, 6'h01, 32'h1234_5678, 32'h1234_5678, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_ADD, '1, 32'h1, 1'b0, 0, 1'b0);            // wraps
    add_instr(OPC_RTYPE, SEL_SUBU, '0, 32'h1, 1'b0, 0, 1'b0);           // wraps
    add_instr(OPC_RTYPE, SEL_AND, 32'hF0F0_F0F0, '1, 1'b0, 1, 1'b0);
    add_instr(SEL_ORI, 6'h3F, 32'h0F0F_0F0F, 32'hF000_0000, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_XOR, '1, 32'h5555_5555, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_NOR, '0, '0, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_SLT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 2, 1'b0);
    add_instr(SEL_SLTIU, 6'h00, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 1'b0);
    // shift amount keeps its low five bits only
    add_instr(OPC_RTYPE, SEL_SLL, 32'h8000_0001, 32'hFFFF_FFE1, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_SRLV, '1, 32'h0000_003F, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_SRA, 32'h8000_0000, 32'h0000_001F, 1'b0, 0, 1'b0);
    add_instr(SEL_LUI, 6'h00, '0, '1, 1'b0, 0, 1'b0);
    // divide corners: by zero, most negative over minus one, rounding
    add_instr(OPC_RTYPE, SEL_DIV, 32'h0000_0007, '0, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_DIVU, '1, '0, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_DIV, 32'h8000_0000, '1, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_DIV, 32'hFFFF_FFF9, 32'h0000_0002, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_DIVU, 32'hFFFF_FFF9, 32'h0000_0002, 1'b0, 0, 1'b1);
    // clear with equal operands: no zero flag, result held
    add_instr(OPC_RTYPE, SEL_ADD, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 0, 1'b0);
    // non r-type opcode equal to a function code aliases that operation
    add_instr(SEL_ADD, 6'h3F, 32'h0000_0010, 32'h0000_0020, 1'b0, 0, 1'b0);
    add_instr(6'h3F, SEL_ADD, 32'h0000_0010, 32'h0000_0020, 1'b0, 0, 1'b0);
    add_instr(OPC_LW, SEL_SUB, 32'h1000_0000, 32'hFFFF_FFFC, 1'b0, 0, 1'b0);
    add_instr(OPC_SW, SEL_NOR, 32'h2000_0000, 32'h0000_0008, 1'b0, 0, 1'b0);
    add_instr(OPC_RTYPE, SEL_SRAV, 32'h7FFF_FFFF, 32'h0000_0004, 1'b0, 0, 1'b0);

    // random part in stretches of differing sender density
    tx_mode = 0;
    stretch = 0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (stretch == 0) begin
        tx_mode = $urandom_range(0, 2);
        stretch = $urandom_range(20, 80);
      end
      stretch--;
      kind = $urandom_range(0, 99);
      fn   = 6'($urandom_range(0, 63));
      if (kind < 55) begin
        opc = OPC_RTYPE;
        fn  = rtype_funcs[$urandom_range(0, rtype_funcs.size() - 1)];
      end else if (kind < 75) begin
        opc = imm_opcodes[$urandom_range(0, imm_opcodes.size() - 1)];
      end else if (kind < 83) begin
        opc = $urandom_range(0, 1) ? OPC_LW : OPC_SW;
      end else begin
        opc = 6'($urandom_range(0, 63));
      end
      a   = pick_operand();
      b   = ($urandom_range(0, 7) == 0) ? a : pick_operand();
      clr = ($urandom_range(0, 19) == 0);
      add_instr(opc, fn, a, b, clr, draw_wait(tx_mode), (i % 400) == 399);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (instr_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (alu_results_due.size() != 0) @(posedge clk_i);
    // catch any stray beat that would follow the last one
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mips_integer_alu_top_test OK");
    end else begin
      $display("mips_integer_alu_top_test NOT OK");
    end
    $finish;
  end

endmodule
